### hdl/tlsc_pkg.sv
package tlsc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Default seeds, used when the matching key word is zero.
  localparam logic [WORD_W-1:0] SEED_A = 32'h13579BDF;
  localparam logic [WORD_W-1:0] SEED_B = 32'h2468ACE0;
  localparam logic [WORD_W-1:0] SEED_C = 32'hFDB97531;

  // Feedback taps, forced upper bits and clear masks of the three registers.
  localparam logic [WORD_W-1:0] TAP_A  = 32'h80000062;
  localparam logic [WORD_W-1:0] TAP_B  = 32'h40000020;
  localparam logic [WORD_W-1:0] TAP_C  = 32'h10000002;
  localparam logic [WORD_W-1:0] FILL_A = 32'h80000000;
  localparam logic [WORD_W-1:0] FILL_B = 32'hC0000000;
  localparam logic [WORD_W-1:0] FILL_C = 32'hF0000000;
  localparam logic [WORD_W-1:0] MASK_A = 32'h7FFFFFFF;
  localparam logic [WORD_W-1:0] MASK_B = 32'h3FFFFFFF;
  localparam logic [WORD_W-1:0] MASK_C = 32'h0FFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_A = 2'd0,
    REG_KEY_B = 2'd1,
    REG_KEY_C = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
  } lfsr_set_t;

endpackage

### hdl/tlsc_in_if.sv
interface tlsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [tlsc_pkg::BYTE_W-1:0] data_byte;
  logic                        restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

### hdl/tlsc_out_if.sv
interface tlsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tlsc_pkg::BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

### hdl/tlsc_cfg_if.sv
interface tlsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tlsc_pkg::CFG_IDX_W-1:0] index;
  logic [tlsc_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/tlsc_key_regs.sv
module tlsc_key_regs (
  input  logic                clk,
  input  logic                rst_n,
  tlsc_cfg_if.sink            cfg,
  output tlsc_pkg::lfsr_set_t seeds
);

  logic [tlsc_pkg::WORD_W-1:0] key_a_r;
  logic [tlsc_pkg::WORD_W-1:0] key_b_r;
  logic [tlsc_pkg::WORD_W-1:0] key_c_r;
  tlsc_pkg::cfg_idx_t          idx;

  assign cfg.ready = 1'b1;
  assign idx = tlsc_pkg::cfg_idx_t'(cfg.index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= '0;
      key_b_r <= '0;
      key_c_r <= '0;
    end else if (cfg.valid) begin
      unique case (idx)
        tlsc_pkg::REG_KEY_A: key_a_r <= cfg.data;
        tlsc_pkg::REG_KEY_B: key_b_r <= cfg.data;
        tlsc_pkg::REG_KEY_C: key_c_r <= cfg.data;
        default: ;
      endcase
    end
  end

  // A zero key word stands for the register's default seed.
  assign seeds.a = (key_a_r == '0) ? tlsc_pkg::SEED_A : key_a_r;
  assign seeds.b = (key_b_r == '0) ? tlsc_pkg::SEED_B : key_b_r;
  assign seeds.c = (key_c_r == '0) ? tlsc_pkg::SEED_C : key_c_r;

endmodule

### hdl/tlsc_lfsr_core.sv
module tlsc_lfsr_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic                        restart,
  input  tlsc_pkg::lfsr_set_t         seeds,
  output logic [tlsc_pkg::BYTE_W-1:0] ks
);

  logic [tlsc_pkg::WORD_W-1:0] a_r, b_r, c_r;
  logic [tlsc_pkg::WORD_W-1:0] a_nxt, b_nxt, c_nxt;
  logic                        bit_b, bit_c;
  logic [tlsc_pkg::BYTE_W-1:0] ks_acc;

  // Eight LFSR steps in one pass: A always steps, its old LSB picks B or C.
  always_comb begin
    a_nxt  = restart ? seeds.a : a_r;
    b_nxt  = restart ? seeds.b : b_r;
    c_nxt  = restart ? seeds.c : c_r;
    bit_b  = b_nxt[0];
    bit_c  = c_nxt[0];
    ks_acc = '0;
    for (int i = 0; i < tlsc_pkg::BYTE_W; i++) begin
      if (a_nxt[0]) begin
        a_nxt = tlsc_pkg::FILL_A | ((a_nxt ^ tlsc_pkg::TAP_A) >> 1);
        bit_b = b_nxt[0];
        if (b_nxt[0]) begin
          b_nxt = tlsc_pkg::FILL_B | ((b_nxt ^ tlsc_pkg::TAP_B) >> 1);
        end else begin
          b_nxt = tlsc_pkg::MASK_B & (b_nxt >> 1);
        end
      end else begin
        a_nxt = tlsc_pkg::MASK_A & (a_nxt >> 1);
        bit_c = c_nxt[0];
        if (c_nxt[0]) begin
          c_nxt = tlsc_pkg::FILL_C | ((c_nxt ^ tlsc_pkg::TAP_C) >> 1);
        end else begin
          c_nxt = tlsc_pkg::MASK_C & (c_nxt >> 1);
        end
      end
      ks_acc = {ks_acc[tlsc_pkg::BYTE_W-2:0], bit_b ^ bit_c};
    end
  end

  assign ks = ks_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= tlsc_pkg::SEED_A;
      b_r <= tlsc_pkg::SEED_B;
      c_r <= tlsc_pkg::SEED_C;
    end else if (step_en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

endmodule

### hdl/three_lfsr_stream_cipher.sv
// Stream cipher on bytes: three 32-bit Galois LFSRs, A picks B or C to step.
// in_ch carries one request per byte: data_byte and a restart flag that
// reloads all three registers from the key before that byte is processed.
// out_ch returns one out_byte per request, data_byte XOR the keystream byte,
// in request order. cfg_ch writes key words A, B and C at indexes 0 to 2;
// other indexes are ignored, cfg_ch is always ready, and a key write takes
// effect at the next restart. Write keys only while the block is idle.
// A request is held in an input register; when it advances, eight LFSR
// steps run in one pass of logic and the result lands in the output register,
// which drives out_ch.valid. One request is taken every cycle while the
// receiver keeps up. The eight-step LFSR update
// sets the clock period. When the receiver stalls, the result waits in the
// output register, one more request is held in the input register, and
// in_ch.ready drops. Reset empties both registers, clears the key words and
// loads the default seeds into the LFSRs.
module three_lfsr_stream_cipher (
  input  logic       clk,
  input  logic       rst_n,
  tlsc_in_if.sink    in_ch,
  tlsc_out_if.source out_ch,
  tlsc_cfg_if.sink   cfg_ch
);

  logic                        in_valid_r;
  logic [tlsc_pkg::BYTE_W-1:0] in_data_r;
  logic                        in_restart_r;
  logic                        out_valid_r;
  logic [tlsc_pkg::BYTE_W-1:0] out_byte_r;
  logic                        advance;
  logic [tlsc_pkg::BYTE_W-1:0] ks;
  tlsc_pkg::lfsr_set_t         seeds;

  tlsc_key_regs u_key_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .seeds (seeds)
  );

  tlsc_lfsr_core u_lfsr_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .restart (in_restart_r),
    .seeds   (seeds),
    .ks      (ks)
  );

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_data_r    <= in_ch.data_byte;
      in_restart_r <= in_ch.restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= in_data_r ^ ks;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

endmodule
